### rtl/blp_pkg.sv
// ----------------------------------------------------------------------------
// blp_pkg
// Shared constants, payload types and latency helpers for the Blinn-Phong
// lighting pipeline.
// ----------------------------------------------------------------------------
package blp_pkg;

  localparam int COORD_BITS         = 16;
  localparam int VEC_W              = COORD_BITS + 1;
  localparam int UNIT_FRAC_BITS_DEF = 15;
  localparam int SHININESS_BITS_DEF = 8;

  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CHAN_W    = 16;
  localparam int PIX_W     = 8;
  localparam int SHIN_RESET = 30;

  // magnitudes are brought under 2^MAG_BITS before the length is taken
  localparam int MAG_BITS   = 20;
  localparam int HALF_SHIFT = MAG_BITS / 2;
  localparam int SUMSQ_W    = 2 * MAG_BITS + 2;
  localparam int SQRT_W     = SUMSQ_W + MAG_BITS;
  localparam int SQRT_STEPS = SQRT_W / 2;
  localparam int ROOT_W     = SQRT_STEPS;

  // saturation limit for the division by 255 of the scaled channel sum
  localparam int SAT_LIMIT = 255 * 256;

  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPECULAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EYE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] normal_x;
    logic signed [COORD_BITS-1:0] normal_y;
    logic signed [COORD_BITS-1:0] normal_z;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } pt_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CFG_W-1:0] ambient;
    logic [CFG_W-1:0] diffuse;
    logic [CFG_W-1:0] specular;
  } shade_cfg_t;

  // abs/shift, square, sum, root steps, quotient bits, output
  function automatic int unit_latency(input int frac);
    return frac + SQRT_STEPS + 5;
  endfunction

  // two dot stages, square-and-multiply, three color stages
  function automatic int shade_latency(input int sbits);
    return 2 * sbits + 5;
  endfunction

endpackage

### rtl/blp_delay.sv
// ----------------------------------------------------------------------------
// blp_delay
// Enabled shift line that keeps side data aligned with a pipelined unit.
// ----------------------------------------------------------------------------
module blp_delay #(
  parameter int W     = 16,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

### rtl/blp_unit.sv
// ----------------------------------------------------------------------------
// blp_unit
// Pipelined vector normalizer: magnitude reduction, sum of squares, one
// root bit per stage, one quotient bit per stage, signed clamp.
// ----------------------------------------------------------------------------
module blp_unit #(
  parameter int IN_W = 17,
  parameter int F    = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IN_W-1:0] vec [3],
  output logic                 out_valid,
  output logic signed [F:0]    unit [3]
);

  import blp_pkg::*;

  localparam int EW     = (IN_W > MAG_BITS) ? IN_W : MAG_BITS;
  localparam int SH_W   = $clog2(EW + 1);
  localparam int QB     = F + 1;
  localparam int DIV_W  = ROOT_W + F + 1;
  localparam int NUM_SH = F + HALF_SHIFT;
  localparam int TAG_W  = 3 * MAG_BITS + 4;
  localparam logic [QB-1:0] ONE_Q = {1'b1, {F{1'b0}}};

  // ---- stage 1: magnitudes, common right shift ----
  logic [IN_W-1:0] mag [3];
  logic [IN_W-1:0] mag_max;
  logic [EW-1:0]   max_ext;
  logic [SH_W-1:0] shamt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i][IN_W-1] ? IN_W'(-vec[i]) : IN_W'(vec[i]);
    end
    mag_max = mag[0];
    if (mag[1] > mag_max) begin
      mag_max = mag[1];
    end
    if (mag[2] > mag_max) begin
      mag_max = mag[2];
    end
    max_ext = EW'(mag_max);
    shamt = '0;
    for (int j = MAG_BITS; j < EW; j++) begin
      if (max_ext[j]) begin
        shamt = SH_W'(j - MAG_BITS + 1);
      end
    end
  end

  logic [MAG_BITS-1:0] m1 [3];
  logic [2:0]          neg1;
  logic                v1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1[i]   <= MAG_BITS'(EW'(mag[i]) >> shamt);
        neg1[i] <= vec[i][IN_W-1];
      end
    end
  end

  // ---- stage 2: squares ----
  logic [2*MAG_BITS-1:0] sq2 [3];
  logic [MAG_BITS-1:0]   m2 [3];
  logic [2:0]            neg2;
  logic                  v2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= m1[i] * m1[i];
      end
      m2   <= m1;
      neg2 <= neg1;
    end
  end

  // ---- stage 3: sum of squares, radicand ----
  logic [SUMSQ_W-1:0] sum_sq;
  logic [SQRT_W-1:0]  x3;
  logic [TAG_W-1:0]   tag3;
  logic               v3;

  assign sum_sq = SUMSQ_W'(sq2[0]) + SUMSQ_W'(sq2[1]) + SUMSQ_W'(sq2[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      x3   <= {sum_sq, {MAG_BITS{1'b0}}};
      tag3 <= {(sum_sq == '0), neg2, m2[2], m2[1], m2[0]};
    end
  end

  // ---- root: one result bit per stage ----
  logic [SQRT_W-1:0] rx [SQRT_STEPS];
  logic [SQRT_W-1:0] rres [SQRT_STEPS];
  logic [TAG_W-1:0]  rtag [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] rv;

  logic [SQRT_W-1:0] rx_in [SQRT_STEPS];
  logic [SQRT_W-1:0] rres_in [SQRT_STEPS];
  logic [TAG_W-1:0]  rtag_in [SQRT_STEPS];
  logic [SQRT_W-1:0] rbit [SQRT_STEPS];
  logic [SQRT_W-1:0] rtrial [SQRT_STEPS];

  always_comb begin
    rx_in[0]   = x3;
    rres_in[0] = '0;
    rtag_in[0] = tag3;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      rx_in[k]   = rx[k-1];
      rres_in[k] = rres[k-1];
      rtag_in[k] = rtag[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rbit[k]   = SQRT_W'(1) << (SQRT_W - 2 - 2 * k);
      rtrial[k] = rres_in[k] + rbit[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        if (rx_in[k] >= rtrial[k]) begin
          rx[k]   <= rx_in[k] - rtrial[k];
          rres[k] <= (rres_in[k] >> 1) + rbit[k];
        end else begin
          rx[k]   <= rx_in[k];
          rres[k] <= rres_in[k] >> 1;
        end
        rtag[k] <= rtag_in[k];
      end
    end
  end

  // ---- divide: one quotient bit per stage, three lanes ----
  logic [DIV_W-1:0] drem [QB][3];
  logic [QB-1:0]    dq [QB][3];
  logic [DIV_W-1:0] ddiv [QB];
  logic [3:0]       dtag [QB];
  logic [QB-1:0]    dv;

  logic [DIV_W-1:0] drem_in [QB][3];
  logic [QB-1:0]    dq_in [QB][3];
  logic [DIV_W-1:0] ddiv_in [QB];
  logic [3:0]       dtag_in [QB];
  logic [DIV_W-1:0] dtrial [QB];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      drem_in[0][i] = DIV_W'(rtag[SQRT_STEPS-1][i*MAG_BITS +: MAG_BITS]) << NUM_SH;
      dq_in[0][i]   = '0;
    end
    ddiv_in[0] = DIV_W'(rres[SQRT_STEPS-1][ROOT_W-1:0]);
    dtag_in[0] = rtag[SQRT_STEPS-1][TAG_W-1 -: 4];
    for (int k = 1; k < QB; k++) begin
      drem_in[k] = drem[k-1];
      dq_in[k]   = dq[k-1];
      ddiv_in[k] = ddiv[k-1];
      dtag_in[k] = dtag[k-1];
    end
    for (int k = 0; k < QB; k++) begin
      dtrial[k] = ddiv_in[k] << (QB - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        for (int i = 0; i < 3; i++) begin
          if (drem_in[k][i] >= dtrial[k]) begin
            drem[k][i] <= drem_in[k][i] - dtrial[k];
            dq[k][i]   <= dq_in[k][i] | (QB'(1) << (QB - 1 - k));
          end else begin
            drem[k][i] <= drem_in[k][i];
            dq[k][i]   <= dq_in[k][i];
          end
        end
        ddiv[k] <= ddiv_in[k];
        dtag[k] <= dtag_in[k];
      end
    end
  end

  // ---- output: clamp to Q1.F and apply sign ----
  logic [QB-1:0] qc [3];
  logic [2:0]    qneg;
  logic          qzero;

  always_comb begin
    qzero = dtag[QB-1][3];
    qneg  = dtag[QB-1][2:0];
    for (int i = 0; i < 3; i++) begin
      if (qneg[i]) begin
        qc[i] = (dq[QB-1][i] > ONE_Q) ? ONE_Q : dq[QB-1][i];
      end else begin
        qc[i] = (dq[QB-1][i] > ONE_Q - 1'b1) ? ONE_Q - 1'b1 : dq[QB-1][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (qzero) begin
          unit[i] <= '0;
        end else if (qneg[i]) begin
          unit[i] <= $signed(-qc[i]);
        end else begin
          unit[i] <= $signed(qc[i]);
        end
      end
    end
  end

  // ---- valid bits ----
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rv        <= '0;
      dv        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      rv        <= {rv[SQRT_STEPS-2:0], v3};
      dv        <= {dv[QB-2:0], rv[SQRT_STEPS-1]};
      out_valid <= dv[QB-1];
    end
  end

endmodule

### rtl/blp_shade.sv
// ----------------------------------------------------------------------------
// blp_shade
// Dot products, specular power by square-and-multiply (one multiply per
// stage), and per-channel color combine with divide by 255 and saturation.
// ----------------------------------------------------------------------------
module blp_shade #(
  parameter int F  = 15,
  parameter int SB = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [F:0]     nu [3],
  input  logic signed [F:0]     lu [3],
  input  logic signed [F:0]     hu [3],
  input  blp_pkg::shade_cfg_t   cfg,
  input  logic [SB-1:0]         shin,
  output logic                  out_valid,
  output blp_pkg::rgb_t         rgb
);

  import blp_pkg::*;

  localparam int QB    = F + 1;
  localparam int PR_W  = 2 * QB;
  localparam int DOT_W = PR_W + 2;
  localparam int NP    = 2 * SB;
  localparam int TOT_W = QB + CHAN_W + 2;
  localparam int Y_W   = TOT_W - F;
  localparam logic [QB-1:0] ONE_Q = {1'b1, {F{1'b0}}};

  // ---- d1: component products ----
  logic signed [PR_W-1:0] pl [3];
  logic signed [PR_W-1:0] ph [3];
  logic v_d1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl[i] <= nu[i] * lu[i];
        ph[i] <= nu[i] * hu[i];
      end
    end
  end

  // ---- d2: sums, positive part, cap at 1.0 ----
  logic signed [DOT_W-1:0] dl;
  logic signed [DOT_W-1:0] dh;
  logic [DOT_W-F-1:0]      dl_sh;
  logic [DOT_W-F-1:0]      dh_sh;
  logic [QB-1:0]           cd_next;
  logic [QB-1:0]           ch_next;
  logic [QB-1:0]           cd2;
  logic [QB-1:0]           ch2;
  logic v_d2;

  always_comb begin
    dl = DOT_W'(pl[0]) + DOT_W'(pl[1]) + DOT_W'(pl[2]);
    dh = DOT_W'(ph[0]) + DOT_W'(ph[1]) + DOT_W'(ph[2]);
    dl_sh = dl[DOT_W-1:F];
    dh_sh = dh[DOT_W-1:F];
    if (dl <= 0) begin
      cd_next = '0;
    end else if (dl_sh > (DOT_W-F)'(ONE_Q)) begin
      cd_next = ONE_Q;
    end else begin
      cd_next = QB'(dl_sh);
    end
    if (dh <= 0) begin
      ch_next = '0;
    end else if (dh_sh > (DOT_W-F)'(ONE_Q)) begin
      ch_next = ONE_Q;
    end else begin
      ch_next = QB'(dh_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd2 <= cd_next;
      ch2 <= ch_next;
    end
  end

  // ---- power: even stage squares, odd stage multiplies on exponent bit ----
  logic [QB-1:0] pp [NP];
  logic [QB-1:0] px [NP];
  logic [QB-1:0] pcd [NP];
  logic [NP-1:0] pv;

  logic [QB-1:0]   pp_in [NP];
  logic [QB-1:0]   px_in [NP];
  logic [QB-1:0]   pcd_in [NP];
  logic [PR_W-1:0] pprod [NP];
  logic [QB-1:0]   pnext [NP];

  always_comb begin
    pp_in[0]  = ONE_Q;
    px_in[0]  = ch2;
    pcd_in[0] = cd2;
    for (int j = 1; j < NP; j++) begin
      pp_in[j]  = pp[j-1];
      px_in[j]  = px[j-1];
      pcd_in[j] = pcd[j-1];
    end
    for (int j = 0; j < NP; j++) begin
      if (j[0] == 1'b0) begin
        pprod[j] = pp_in[j] * pp_in[j];
        pnext[j] = QB'(pprod[j] >> F);
      end else begin
        pprod[j] = pp_in[j] * px_in[j];
        pnext[j] = shin[SB - 1 - (j >> 1)] ? QB'(pprod[j] >> F) : pp_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NP; j++) begin
        pp[j]  <= pnext[j];
        px[j]  <= px_in[j];
        pcd[j] <= pcd_in[j];
      end
    end
  end

  // ---- c1: weighted terms ----
  logic [QB-1:0]          cs_c;
  logic [CHAN_W-1:0]      tamb [3];
  logic [QB+CHAN_W-1:0]   tdif [3];
  logic [QB+CHAN_W-1:0]   tspe [3];
  logic v_c1;

  // no specular highlight on the unlit side
  assign cs_c = (pcd[NP-1] == '0) ? '0 : pp[NP-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tamb[i] <= cfg.ambient[i*CHAN_W +: CHAN_W];
        tdif[i] <= pcd[NP-1] * cfg.diffuse[i*CHAN_W +: CHAN_W];
        tspe[i] <= cs_c * cfg.specular[i*CHAN_W +: CHAN_W];
      end
    end
  end

  // ---- c2: channel sum, drop fraction ----
  logic [TOT_W-1:0] tot [3];
  logic [Y_W-1:0]   y [3];
  logic v_c2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (TOT_W'(tamb[i]) << F) + TOT_W'(tdif[i]) + TOT_W'(tspe[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        y[i] <= Y_W'(tot[i] >> F);
      end
    end
  end

  // ---- c3: divide by 255 (reciprocal estimate plus one correction) ----
  logic [15:0]      y16 [3];
  logic [23:0]      p257 [3];
  logic [PIX_W-1:0] q0 [3];
  logic [16:0]      q255 [3];
  logic [16:0]      rem [3];
  logic [PIX_W-1:0] chan [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y16[i]  = y[i][15:0];
      p257[i] = {y16[i], 8'h00} + 24'(y16[i]);
      q0[i]   = p257[i][23:16];
      q255[i] = {1'b0, q0[i], 8'h00} - 17'(q0[i]);
      rem[i]  = 17'(y16[i]) - q255[i];
      if (y[i] >= Y_W'(SAT_LIMIT)) begin
        chan[i] = '1;
      end else if (rem[i] >= 17'd255) begin
        chan[i] = q0[i] + 1'b1;
      end else begin
        chan[i] = q0[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb.red   <= chan[0];
      rgb.green <= chan[1];
      rgb.blue  <= chan[2];
    end
  end

  // ---- valid bits ----
  always_ff @(posedge clk) begin
    if (rst) begin
      v_d1      <= 1'b0;
      v_d2      <= 1'b0;
      pv        <= '0;
      v_c1      <= 1'b0;
      v_c2      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_d1      <= in_valid;
      v_d2      <= v_d1;
      pv        <= {pv[NP-2:0], v_d2};
      v_c1      <= pv[NP-1];
      v_c2      <= v_c1;
      out_valid <= v_c2;
    end
  end

endmodule

### rtl/blinn_phong_lighting.sv
// Throughput: one word per cycle; the whole pipeline advances on one enable
// and holds while a finished result waits at the output.
// Reset (rst, synchronous): clears every valid bit and the configuration
// registers to 0, shininess to 30. No clearing pass; words are taken the cycle after reset.
// ----------------------------------------------------------------------------
// blinn_phong_lighting
// Blinn-Phong shading of one surface point per word: light and eye vector
// forming, four normalizers (N, L, E in parallel, then H), then shading.
// ----------------------------------------------------------------------------
module blinn_phong_lighting #(
  parameter int UNIT_FRAC_BITS = blp_pkg::UNIT_FRAC_BITS_DEF,
  parameter int SHININESS_BITS = blp_pkg::SHININESS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pt_valid,
  output logic                          pt_ready,
  input  blp_pkg::pt_t                  pt_data,
  output logic                          rgb_valid,
  input  logic                          rgb_ready,
  output blp_pkg::rgb_t                 rgb_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [blp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blp_pkg::CFG_W-1:0]     cfg_data
);

  import blp_pkg::*;

  localparam int F     = UNIT_FRAC_BITS;
  localparam int QB    = F + 1;
  localparam int LAT_U = unit_latency(F);

  // ---- configuration ----
  shade_cfg_t                shade_cfg;
  logic [CFG_W-1:0]          reg_light;
  logic [CFG_W-1:0]          reg_eye;
  logic [SHININESS_BITS-1:0] reg_shin;
  logic [1:0]                reg_mode;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      shade_cfg <= '0;
      reg_light <= '0;
      reg_eye   <= '0;
      reg_shin  <= SHININESS_BITS'(SHIN_RESET);
      reg_mode  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AMBIENT:  shade_cfg.ambient  <= cfg_data;
        REG_DIFFUSE:  shade_cfg.diffuse  <= cfg_data;
        REG_SPECULAR: shade_cfg.specular <= cfg_data;
        REG_LIGHT:    reg_light <= cfg_data;
        REG_EYE:      reg_eye   <= cfg_data;
        REG_SHIN:     reg_shin  <= cfg_data[SHININESS_BITS-1:0];
        REG_MODE:     reg_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // ---- pipeline enable ----
  logic en;

  assign en       = !rgb_valid || rgb_ready;
  assign pt_ready = en && !rst;

  // ---- front stage: normal, light and eye vectors ----
  logic signed [COORD_BITS-1:0] nc [3];
  logic signed [COORD_BITS-1:0] pc [3];
  logic signed [COORD_BITS-1:0] lc [3];
  logic signed [COORD_BITS-1:0] ec [3];
  logic signed [VEC_W-1:0]      n0 [3];
  logic signed [VEC_W-1:0]      l0 [3];
  logic signed [VEC_W-1:0]      e0 [3];
  logic                         v0;

  always_comb begin
    nc[0] = pt_data.normal_x;
    nc[1] = pt_data.normal_y;
    nc[2] = pt_data.normal_z;
    pc[0] = pt_data.point_x;
    pc[1] = pt_data.point_y;
    pc[2] = pt_data.point_z;
    for (int i = 0; i < 3; i++) begin
      lc[i] = $signed(reg_light[i*COORD_BITS +: COORD_BITS]);
      ec[i] = $signed(reg_eye[i*COORD_BITS +: COORD_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n0[i] <= VEC_W'(nc[i]);
        // directional light / orthographic eye use the register as is
        l0[i] <= reg_mode[0] ? VEC_W'(lc[i]) : VEC_W'(lc[i]) - VEC_W'(pc[i]);
        e0[i] <= reg_mode[1] ? VEC_W'(ec[i]) : VEC_W'(ec[i]) - VEC_W'(pc[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= pt_valid && pt_ready;
    end
  end

  // ---- first normalizers ----
  logic signed [F:0] nu [3];
  logic signed [F:0] lu [3];
  logic signed [F:0] eu [3];
  logic              v_u1;
  logic              v_un;
  logic              v_ue;

  blp_unit #(.IN_W(VEC_W), .F(F)) u_unit_n (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .vec(n0),
    .out_valid(v_un), .unit(nu)
  );

  blp_unit #(.IN_W(VEC_W), .F(F)) u_unit_l (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .vec(l0),
    .out_valid(v_u1), .unit(lu)
  );

  blp_unit #(.IN_W(VEC_W), .F(F)) u_unit_e (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .vec(e0),
    .out_valid(v_ue), .unit(eu)
  );

  // ---- half vector ----
  logic signed [F+1:0] h [3];
  logic signed [F:0]   hu [3];
  logic                v_u2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h[i] = {lu[i][F], lu[i]} + {eu[i][F], eu[i]};
    end
  end

  blp_unit #(.IN_W(F + 2), .F(F)) u_unit_h (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_u1), .vec(h),
    .out_valid(v_u2), .unit(hu)
  );

  // N and L wait alongside the half-vector normalizer
  logic [6*QB-1:0]   side_d;
  logic [6*QB-1:0]   side_q;
  logic signed [F:0] nu_d [3];
  logic signed [F:0] lu_d [3];

  assign side_d = {nu[2], nu[1], nu[0], lu[2], lu[1], lu[0]};

  blp_delay #(.W(6 * QB), .DEPTH(LAT_U)) u_side (
    .clk(clk), .en(en), .d(side_d), .q(side_q)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lu_d[i] = $signed(side_q[i*QB +: QB]);
      nu_d[i] = $signed(side_q[(i+3)*QB +: QB]);
    end
  end

  // ---- shading ----
  blp_shade #(.F(F), .SB(SHININESS_BITS)) u_shade (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_u2),
    .nu(nu_d), .lu(lu_d), .hu(hu), .cfg(shade_cfg), .shin(reg_shin),
    .out_valid(rgb_valid), .rgb(rgb_data)
  );

  // ---- checks ----
  a_rst_clears: assert property (@(posedge clk) rst |=> !rgb_valid)
    else $error("result valid right after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && !rgb_ready) |-> !pt_ready)
    else $error("word taken while the pipeline is stalled");

  a_units_aligned: assert property (@(posedge clk) disable iff (rst)
    (v_un == v_u1) && (v_ue == v_u1))
    else $error("first normalizers out of step");

endmodule

### test/blinn_phong_lighting_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blinn_phong_lighting_tb
// Drives surface points through the lighting pipeline under several register
// settings and compares each colour word with a bit-exact predictor.
// ----------------------------------------------------------------------------
module blinn_phong_lighting_tb;
  import blp_pkg::*;

  localparam int FRAC = 15;
  localparam int SBITS = 8;
  localparam longint ONE = 64'd1 << FRAC;
  localparam int LATENCY = 124;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pt_valid = 1'b0;
  logic pt_ready;
  pt_t pt_data = '0;
  logic rgb_valid;
  logic rgb_ready = 1'b0;
  rgb_t rgb_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  blinn_phong_lighting dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow registers
  logic [47:0] amb_q, dif_q, spe_q, light_q, eye_q;
  logic [7:0] shin_q;
  logic [1:0] mode_q;

  rgb_t colour_q[$];
  int errors = 0;
  bit sink_idle = 1'b1;   // random stalls on the receiver
  bit src_idle = 1'b1;    // random gaps on the sender
  bit hold_sink = 1'b0;
  int sink_gap = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic longint isqrt(input longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  typedef longint vec3_t[3];

  function automatic vec3_t unit_vec(input vec3_t v);
    vec3_t o;
    longint unsigned m[3], mx, s, r, q;
    bit neg[3];
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    while (mx >= (64'd1 << 20)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    if (s == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
      return o;
    end
    r = isqrt(s << 20);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << (FRAC + 10)) / r;
      if (neg[i]) begin
        if (q > ONE) q = ONE;
        o[i] = -longint'(q);
      end else begin
        if (q > ONE - 1) q = ONE - 1;
        o[i] = q;
      end
    end
    return o;
  endfunction

  function automatic longint clamp_dot(input vec3_t a, input vec3_t b);
    longint d, q;
    d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    if (d <= 0) return 0;
    q = d >>> FRAC;
    return q > ONE ? ONE : q;
  endfunction

  function automatic rgb_t shade(input pt_t p);
    vec3_t n, pp, l, e, h, nu, lu, eu, hu;
    longint cd, cs, pw, a, d, s, tot;
    logic [7:0] ch[3];
    rgb_t o;
    n[0] = p.normal_x; n[1] = p.normal_y; n[2] = p.normal_z;
    pp[0] = p.point_x; pp[1] = p.point_y; pp[2] = p.point_z;
    for (int i = 0; i < 3; i++) begin
      l[i] = longint'($signed(light_q[16*i +: 16]));
      e[i] = longint'($signed(eye_q[16*i +: 16]));
      if (!mode_q[0]) l[i] -= pp[i];
      if (!mode_q[1]) e[i] -= pp[i];
    end
    nu = unit_vec(n);
    lu = unit_vec(l);
    eu = unit_vec(e);
    for (int i = 0; i < 3; i++) h[i] = lu[i] + eu[i];
    hu = unit_vec(h);
    cd = clamp_dot(nu, lu);
    cs = 0;
    if (cd != 0) begin
      s = clamp_dot(nu, hu);
      pw = ONE;
      for (int b = SBITS - 1; b >= 0; b--) begin
        pw = (pw * pw) >> FRAC;
        if (shin_q[b]) pw = (pw * s) >> FRAC;
      end
      cs = pw;
    end
    for (int i = 0; i < 3; i++) begin
      a = amb_q[16*i +: 16];
      d = dif_q[16*i +: 16];
      s = spe_q[16*i +: 16];
      tot = (a * ONE + cd * d + cs * s) / (255 * ONE);
      ch[i] = tot > 255 ? 8'd255 : tot[7:0];
    end
    o.red = ch[0];
    o.green = ch[1];
    o.blue = ch[2];
    return o;
  endfunction

  // receiver: random stall bursts, plus a long hold when asked
  always @(negedge clk) begin
    if (sink_gap == 0 && sink_idle && $urandom_range(0, 5) == 0)
      sink_gap = $urandom_range(1, 5);
    if (hold_sink || sink_gap != 0) rgb_ready <= 1'b0;
    else rgb_ready <= 1'b1;
    if (sink_gap != 0) sink_gap--;
  end

  always @(posedge clk) begin
    if (!rst && rgb_valid && rgb_ready) begin
      if (colour_q.size() == 0) begin
        report("unexpected word", rgb_data, 0);
      end else begin
        rgb_t w;
        w = colour_q.pop_front();
        if (rgb_data.red !== w.red) report("red", rgb_data.red, w.red);
        if (rgb_data.green !== w.green) report("green", rgb_data.green, w.green);
        if (rgb_data.blue !== w.blue) report("blue", rgb_data.blue, w.blue);
      end
    end
  end

  // valid stays high between back-to-back words; a random gap or drain drops it
  task automatic send_point(input pt_t p);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      pt_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    pt_valid <= 1'b1;
    pt_data <= p;
    @(posedge clk);
    while (!pt_ready) @(posedge clk);
    colour_q = {colour_q, shade(p)};
    @(negedge clk);
  endtask

  task automatic drain();
    pt_valid <= 1'b0;
    while (colour_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_AMBIENT: amb_q = v;
      REG_DIFFUSE: dif_q = v;
      REG_SPECULAR: spe_q = v;
      REG_LIGHT: light_q = v;
      REG_EYE: eye_q = v;
      REG_SHIN: shin_q = v[7:0];
      REG_MODE: mode_q = v[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(input logic [47:0] a, d, s, l, e, input logic [7:0] sh,
                         input logic [1:0] md);
    write_reg(REG_AMBIENT, a);
    write_reg(REG_DIFFUSE, d);
    write_reg(REG_SPECULAR, s);
    write_reg(REG_LIGHT, l);
    write_reg(REG_EYE, e);
    write_reg(REG_SHIN, sh);
    write_reg(REG_MODE, md);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pt_t rand_point();
    pt_t p;
    p.normal_x = rand_coord(); p.normal_y = rand_coord(); p.normal_z = rand_coord();
    p.point_x = rand_coord(); p.point_y = rand_coord(); p.point_z = rand_coord();
    return p;
  endfunction

  function automatic logic [47:0] rand_vec();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic logic [47:0] rand_prod();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  task automatic test_reset_values();
    pt_t p;
    amb_q = '0; dif_q = '0; spe_q = '0; light_q = '0; eye_q = '0;
    shin_q = 8'(SHIN_RESET); mode_q = '0;
    p = '0;
    send_point(p);
    p.normal_z = 16'sd100;
    send_point(p);
    drain();
  endtask

  task automatic test_directed();
    pt_t p;
    // light along +z directional, eye orthographic along +z
    set_all({16'd2000, 16'd1000, 16'd500}, {16'd60000, 16'd30000, 16'd65025},
            {16'd65535, 16'd20000, 16'd40000}, {16'sd1000, 16'sd0, 16'sd0},
            {16'sd1, 16'sd0, 16'sd0}, 8'd30, 2'd3);
    p = '0;
    send_point(p);                                  // zero normal
    p.normal_z = 16'sd1;          send_point(p);    // aligned
    p.normal_z = -16'sd1;         send_point(p);    // facing away
    p.normal_z = 16'h7fff;        send_point(p);
    p.normal_z = 16'h8000;        send_point(p);
    p = '0; p.normal_x = 16'sd1;  send_point(p);    // N.L = 0
    p = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff}; send_point(p);
    p = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000}; send_point(p);
    drain();
    // shininess zero, opposing eye nearly cancels the half vector
    write_reg(REG_SHIN, 8'd0);
    write_reg(REG_EYE, {-16'sd1, 16'sd0, 16'sd0});
    p = '0; p.normal_z = 16'sd5; send_point(p);
    p.normal_x = 16'sd3; send_point(p);
    drain();
    // point light and eye, extremes of products and shininess
    set_all('1, '1, '1, {16'h7fff, 16'h8000, 16'h7fff}, {16'h8000, 16'h7fff, 16'h8000},
            8'd255, 2'd0);
    p = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000}; send_point(p);
    p = '{16'sd1, 16'sd1, 16'sd1, 16'h0, 16'h0, 16'h0}; send_point(p);
    p = '{16'h0, 16'h0, 16'sd1, 16'h7fff, 16'h8000, 16'h7fff}; send_point(p); // point on light
    drain();
    write_reg(REG_SHIN, 8'd1);
    p = '{16'h0, 16'h0, 16'sd1, 16'sd0, 16'sd0, -16'sd100}; send_point(p);
    drain();
    write_reg(REG_MODE, 2'd1);
    p = '{16'sd7, -16'sd3, 16'sd9, 16'sd50, 16'sd60, -16'sd70}; send_point(p);
    drain();
    write_reg(REG_MODE, 2'd2);
    send_point(p);
    drain();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 12; phase++) begin
      set_all(phase == 0 ? 48'd0 : rand_prod(), rand_prod(), rand_prod(), rand_vec(),
              rand_vec(), phase == 1 ? 8'd255 : 8'($urandom_range(1, 255)),
              2'($urandom_range(0, 3)));
      for (int k = 0; k < 120; k++) send_point(rand_point());
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_sink = 1'b0;
      end
      for (int k = 0; k < 250; k++) send_point(rand_point());
    join
    drain();   // sender waits for every result here
  endtask

  task automatic test_full_rate();
    sink_idle = 1'b0;
    src_idle = 1'b0;
    for (int k = 0; k < 100; k++) send_point(rand_point());
    drain();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed();
    test_random_settings();
    test_backpressure();
    test_full_rate();
    if (errors == 0 && colour_q.size() == 0) begin
      $display("blinn_phong_lighting test passed");
    end else begin
      $display("blinn_phong_lighting test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("blinn_phong_lighting test failed");
    $finish;
  end

endmodule
